// ===== rtl/iph_pkg.sv =====
// Package for the identifier polynomial hash: the modulus, the character code
// table and the small constant-division helpers used by the hash update.
// No dependencies.
package iph_pkg;

  localparam int unsigned HashW  = 21;
  localparam int unsigned CountW = 5;
  localparam int unsigned CodeW  = 6;

  // Prime modulus; note that HashMod = 3 * 2**19 + 5.
  localparam logic [HashW-1:0]  HashMod  = 21'd1572869;
  localparam logic [CountW-1:0] CountCap = 5'd31;

  localparam logic [7:0] ChEnd        = 8'h00;
  localparam logic [7:0] ChDigitLo    = 8'h30;
  localparam logic [7:0] ChDigitHi    = 8'h39;
  localparam logic [7:0] ChUpperLo    = 8'h41;
  localparam logic [7:0] ChUpperHi    = 8'h5A;
  localparam logic [7:0] ChLowerLo    = 8'h61;
  localparam logic [7:0] ChLowerHi    = 8'h7A;
  localparam logic [7:0] ChUnderscore = 8'h5F;

  localparam logic [CodeW-1:0] CodeUpperBase  = 6'd10;
  localparam logic [CodeW-1:0] CodeLowerBase  = 6'd36;
  localparam logic [CodeW-1:0] CodeUnderscore = 6'd62;

  typedef struct packed {
    logic             ok;
    logic [CodeW-1:0] code;
  } char_class_t;

  // Maps a byte to its code; a byte outside the set gets code 0 and ok low.
  function automatic char_class_t char_code(input logic [7:0] b);
    char_class_t r;
    logic [7:0]  d;
    r = '{ok: 1'b1, code: '0};
    d = 8'd0;
    if (b >= ChDigitLo && b <= ChDigitHi) begin
      d      = b - ChDigitLo;
      r.code = d[CodeW-1:0];
    end else if (b >= ChUpperLo && b <= ChUpperHi) begin
      d      = b - ChUpperLo;
      r.code = d[CodeW-1:0] + CodeUpperBase;
    end else if (b >= ChLowerLo && b <= ChLowerHi) begin
      d      = b - ChLowerLo;
      r.code = d[CodeW-1:0] + CodeLowerBase;
    end else if (b == ChUnderscore) begin
      r.code = CodeUnderscore;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  // Floor of a/3 for an 8-bit value, by multiplying with 171/512.
  function automatic logic [6:0] div3(input logic [7:0] a);
    logic [15:0] p;
    p = {8'd0, a} * 16'd171;
    return p[15:9];
  endfunction

  // Remainder of a/3 for an 8-bit value.
  function automatic logic [1:0] mod3(input logic [7:0] a);
    logic [8:0] t;
    t = {1'b0, a} - ({2'b00, div3(a)} * 9'd3);
    return t[1:0];
  endfunction

endpackage

// ===== rtl/iph_hash_step.sv =====
// One Horner step of the hash, h' = (h * 63 + code(byte)) mod 1572869,
// as combinational logic. Depends on iph_pkg.
module iph_hash_step (
  input  logic [iph_pkg::HashW-1:0] hash_i,
  input  logic [7:0]                byte_i,
  output logic [iph_pkg::HashW-1:0] hash_o,
  output logic                      bad_o
);

  iph_pkg::char_class_t cls;
  logic [26:0]                 prod;
  logic [7:0]                  hi;
  logic [18:0]                 lo;
  logic [20:0]                 folded;
  logic [9:0]                  fold_sub;
  logic [21:0]                 diff;
  logic [21:0]                 wrapped;

  assign cls  = iph_pkg::char_code(byte_i);
  assign bad_o = ~cls.ok;

  // h * 63 + code, at most 27 bits.
  assign prod = {hash_i, 6'd0} - {6'd0, hash_i} + {21'd0, cls.code};

  // Write prod = hi * 2^19 + lo. Since 3 * 2^19 = M - 5, the upper part
  // folds into (hi mod 3) * 2^19 - 5 * floor(hi / 3), which leaves a value
  // within one modulus below zero of the final residue.
  assign hi       = prod[26:19];
  assign lo       = prod[18:0];
  assign folded   = {iph_pkg::mod3(hi), lo};
  assign fold_sub = {3'd0, iph_pkg::div3(hi)} * 10'd5;
  assign diff     = {1'b0, folded} - {12'd0, fold_sub};
  assign wrapped  = diff + {1'b0, iph_pkg::HashMod};

  assign hash_o = diff[21] ? wrapped[20:0] : diff[20:0];

endmodule

// ===== rtl/identifier_polynomial_hash.sv =====
// Top level of the identifier polynomial hash: input register, hash state
// and result register. Depends on iph_pkg and iph_hash_step.
//
// Usage:
// Identifier characters arrive one byte per transfer on the input channel
// (in_valid_i / in_stall_o / char_byte_i). Each byte maps to a code 0..62
// (digits, upper case, lower case, underscore) and updates the running hash
// h = (h * 63 + code) mod 1572869. Only the first MAX_CHARS characters of a
// name (at most 31) are hashed and counted; later ones are dropped. A byte
// outside the identifier set counts with code 0 and raises bad_char.
// A zero byte ends the name: one transfer on the output channel
// (out_valid_o / out_stall_i) carries hash_value, name_length and bad_char,
// and the state clears for the next name. Other bytes give no output.
//
// Timing: the input stage takes one byte per clock unless it is stalled. A
// byte is registered at the input stage; an ordinary byte is folded into the
// state in the following cycle, as the hash update is combinational. A zero
// byte moves from the input stage into the result register once that is free.
// When the receiver stalls, the result register holds its contents; ordinary
// characters keep flowing, and only a second zero byte waits in the input
// stage until the pending result has been taken.
// Reset clears the hash state, the count, the error flag and both stages.
module identifier_polynomial_hash #(
  parameter int unsigned MAX_CHARS = 31
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [7:0]                 char_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [iph_pkg::HashW-1:0]  hash_value_o,
  output logic [iph_pkg::CountW-1:0] name_length_o,
  output logic                       bad_char_o
);

  // The counter is five bits wide, so the limit saturates at 31.
  localparam logic [iph_pkg::CountW-1:0] Limit =
    (MAX_CHARS > 31) ? iph_pkg::CountCap : MAX_CHARS[iph_pkg::CountW-1:0];

  // Input stage.
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;

  // Hash state.
  logic [iph_pkg::HashW-1:0]  hash_q, hash_d;
  logic [iph_pkg::CountW-1:0] count_q;
  logic                       err_q;

  // Result register.
  logic                       out_valid_q;
  logic [iph_pkg::HashW-1:0]  out_hash_q;
  logic [iph_pkg::CountW-1:0] out_len_q;
  logic                       out_bad_q;

  logic is_end;
  logic out_free;
  logic s1_adv;
  logic in_accept;
  logic step_bad;
  logic take_char;

  iph_hash_step u_step (
    .hash_i (hash_q),
    .byte_i (s1_byte_q),
    .hash_o (hash_d),
    .bad_o  (step_bad)
  );

  // A terminator needs room in the result register; other bytes never wait.
  assign is_end    = (s1_byte_q == iph_pkg::ChEnd);
  assign out_free  = ~out_valid_q | ~out_stall_i;
  assign s1_adv    = s1_valid_q & (~is_end | out_free);
  assign in_stall_o = s1_valid_q & ~s1_adv;
  assign in_accept = in_valid_i & ~in_stall_o;
  assign take_char = s1_adv & ~is_end & (count_q < Limit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      hash_q      <= '0;
      count_q     <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end

      if (s1_adv && is_end) begin
        hash_q  <= '0;
        count_q <= '0;
        err_q   <= 1'b0;
      end else if (take_char) begin
        hash_q  <= hash_d;
        count_q <= count_q + 1'b1;
        err_q   <= err_q | step_bad;
      end

      if (s1_adv && is_end) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_byte_q <= char_byte_i;
    end
    if (s1_adv && is_end) begin
      out_hash_q <= hash_q;
      out_len_q  <= count_q;
      out_bad_q  <= err_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hash_value_o  = out_hash_q;
  assign name_length_o = out_len_q;
  assign bad_char_o    = out_bad_q;

endmodule

// ===== rtl/iph_checker.sv =====
// Port-level checks for the identifier polynomial hash, attached to the top
// level by the bind statement at the end. Depends on iph_pkg.
module iph_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [iph_pkg::HashW-1:0]  hash_value_o,
  input logic [iph_pkg::CountW-1:0] name_length_o,
  input logic                       bad_char_o
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result does not change.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(hash_value_o) && $stable(name_length_o) && $stable(bad_char_o))
    else $error("result changed while stalled");

  // The hash is always a reduced residue.
  a_hash_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> hash_value_o < iph_pkg::HashMod)
    else $error("hash value not reduced");

  // An error can only come from a counted character.
  a_bad_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_char_o |-> name_length_o != '0)
    else $error("error flag on an empty name");

  // An empty name always hashes to zero.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && name_length_o == '0 |-> hash_value_o == '0)
    else $error("empty name with nonzero hash");

endmodule

bind identifier_polynomial_hash iph_checker u_iph_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .hash_value_o  (hash_value_o),
  .name_length_o (name_length_o),
  .bad_char_o    (bad_char_o)
);

// ===== dv/identifier_polynomial_hash_tb.sv =====
// Self-checking testbench for identifier_polynomial_hash: streams identifier bytes,
// predicts the hash, length and error flag of every name and checks each result.
// Depends on iph_pkg and the identifier_polynomial_hash RTL.
`timescale 1ns / 1ps

module identifier_polynomial_hash_tb;

  // The instance uses the default limit. The counter is five bits wide, so the
  // effective limit never exceeds 31 characters.
  localparam int unsigned MaxChars  = 31;
  localparam int unsigned NameLimit = (MaxChars > 31) ? 31 : MaxChars;
  localparam int unsigned HashBase  = 63;

  typedef struct packed {
    logic [iph_pkg::HashW-1:0]  hash_value;
    logic [iph_pkg::CountW-1:0] name_length;
    logic                       bad_char;
  } name_result_t;

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       in_valid_i  = 1'b0;
  logic                       in_stall_o;
  logic [7:0]                 char_byte_i = 8'd0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic [iph_pkg::HashW-1:0]  hash_value_o;
  logic [iph_pkg::CountW-1:0] name_length_o;
  logic                       bad_char_o;

  // Bytes waiting to be driven, and the name results still owed by the block.
  logic [7:0]        pending_bytes[$];
  name_result_t      expected_names[$];

  // Predicted hash state of the name being received.
  logic [iph_pkg::HashW-1:0]  acc_hash = '0;
  logic [iph_pkg::CountW-1:0] acc_len  = '0;
  logic                       acc_bad  = 1'b0;

  int unsigned       send_idle_pct = 0;
  int unsigned       recv_idle_pct = 0;
  int unsigned       mismatches    = 0;
  logic              in_fire       = 1'b0;

  identifier_polynomial_hash #(
    .MAX_CHARS(MaxChars)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .char_byte_i   (char_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .hash_value_o  (hash_value_o),
    .name_length_o (name_length_o),
    .bad_char_o    (bad_char_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("%0t ns: mismatch: %s", $realtime, msg);
  endtask

  // Folds one accepted byte into the predicted state. A zero byte closes the
  // name: its hash, length and error flag become the next expected result and
  // the state starts over for the following name.
  task automatic fold_char(input logic [7:0] b);
    int unsigned code;
    logic        in_set;
    int unsigned next_hash;
    code   = 0;
    in_set = 1'b1;
    if (b == iph_pkg::ChEnd) begin
      expected_names.push_back('{hash_value: acc_hash, name_length: acc_len,
                                 bad_char: acc_bad});
      acc_hash = '0;
      acc_len  = '0;
      acc_bad  = 1'b0;
    end else if (acc_len < NameLimit) begin
      // Digits first, then upper case, lower case and finally the underscore.
      if (b >= iph_pkg::ChDigitLo && b <= iph_pkg::ChDigitHi) begin
        code = 32'(b) - 32'(iph_pkg::ChDigitLo);
      end else if (b >= iph_pkg::ChUpperLo && b <= iph_pkg::ChUpperHi) begin
        code = 32'(b) - 32'(iph_pkg::ChUpperLo) + 10;
      end else if (b >= iph_pkg::ChLowerLo && b <= iph_pkg::ChLowerHi) begin
        code = 32'(b) - 32'(iph_pkg::ChLowerLo) + 36;
      end else if (b == iph_pkg::ChUnderscore) begin
        code = 62;
      end else begin
        in_set = 1'b0;
      end
      // The residue stays below 2**21, so the product fits in 32 bits.
      next_hash = (int'(acc_hash) * HashBase + code) % int'(iph_pkg::HashMod);
      acc_hash  = next_hash[iph_pkg::HashW-1:0];
      acc_len   = acc_len + 1'b1;
      if (!in_set) begin
        acc_bad = 1'b1;
      end
    end
    // Bytes past the limit leave the state untouched.
  endtask

  // Queues one random name and its terminating zero byte. Most names are short;
  // some fill the limit exactly and some run past it so that the tail is dropped.
  task automatic queue_random_name(output int unsigned n_bytes);
    int unsigned name_len;
    int unsigned pick;
    int unsigned k;
    logic [7:0]  b;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      name_len = 0;
    end else if (pick < 70) begin
      name_len = $urandom_range(1, 12);
    end else if (pick < 85) begin
      name_len = $urandom_range(25, 31);
    end else begin
      name_len = $urandom_range(32, 45);
    end
    for (int i = 0; i < name_len; i++) begin
      if ($urandom_range(0, 99) < 85) begin
        k = $urandom_range(0, 62);
        if (k < 10) begin
          b = 8'(iph_pkg::ChDigitLo + k);
        end else if (k < 36) begin
          b = 8'(iph_pkg::ChUpperLo + (k - 10));
        end else if (k < 62) begin
          b = 8'(iph_pkg::ChLowerLo + (k - 36));
        end else begin
          b = iph_pkg::ChUnderscore;
        end
      end else begin
        // Any nonzero byte, which also reaches every bit of the field.
        b = 8'($urandom_range(1, 255));
      end
      pending_bytes.push_back(b);
    end
    pending_bytes.push_back(iph_pkg::ChEnd);
    n_bytes = name_len + 1;
  endtask

  // Sender: a byte that was not taken stays on the bus unchanged; otherwise the
  // next byte goes out unless this cycle is picked as an idle one.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_fire) begin
        in_valid_i <= 1'b1;
      end else if (pending_bytes.size() != 0 &&
                   $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid_i  <= 1'b1;
        char_byte_i <= pending_bytes.pop_front();
      end else begin
        in_valid_i  <= 1'b0;
        char_byte_i <= 8'($urandom_range(0, 255));
      end
    end
  end

  // Receiver: stalls at random while a phase asks for it.
  always @(negedge clk_i) begin
    out_stall_i <= rst_ni && ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Monitor: checks the result transfer of this edge against the oldest
  // expectation, then feeds an accepted byte to the predictor. Both happen in
  // one block so their order within the edge is fixed.
  always @(posedge clk_i) begin
    name_result_t want;
    if (!rst_ni) begin
      in_fire <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_names.size() == 0) begin
          report_mismatch($sformatf("result with no name pending: hash %0d len %0d bad %0b",
                                    hash_value_o, name_length_o, bad_char_o));
        end else begin
          want = expected_names.pop_front();
          if (hash_value_o !== want.hash_value) begin
            report_mismatch($sformatf("hash_value %0d, expected %0d",
                                      hash_value_o, want.hash_value));
          end
          if (name_length_o !== want.name_length) begin
            report_mismatch($sformatf("name_length %0d, expected %0d",
                                      name_length_o, want.name_length));
          end
          if (bad_char_o !== want.bad_char) begin
            report_mismatch($sformatf("bad_char %0b, expected %0b",
                                      bad_char_o, want.bad_char));
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        fold_char(char_byte_i);
      end
      in_fire <= in_valid_i && !in_stall_o;
    end
  end

  // Stimulus and sequencing of the three idling phases. Between phases the
  // sender holds off until every result owed so far has been taken.
  initial begin
    int unsigned queued;
    int unsigned n_bytes;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed names: the empty name, one character of each boundary of the set,
    // then bytes just outside each range and at the extremes of the byte.
    pending_bytes.push_back(iph_pkg::ChEnd);
    pending_bytes.push_back(8'h30);
    pending_bytes.push_back(8'h39);
    pending_bytes.push_back(8'h41);
    pending_bytes.push_back(8'h5A);
    pending_bytes.push_back(8'h61);
    pending_bytes.push_back(8'h7A);
    pending_bytes.push_back(8'h5F);
    pending_bytes.push_back(iph_pkg::ChEnd);
    pending_bytes.push_back(8'h01);
    pending_bytes.push_back(8'h2F);
    pending_bytes.push_back(8'h3A);
    pending_bytes.push_back(8'h40);
    pending_bytes.push_back(8'h5B);
    pending_bytes.push_back(8'h5E);
    pending_bytes.push_back(8'h60);
    pending_bytes.push_back(8'h7B);
    pending_bytes.push_back(8'h80);
    pending_bytes.push_back(8'hFF);
    pending_bytes.push_back(iph_pkg::ChEnd);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 18;
          recv_idle_pct = 69;
        end
        1: begin
          send_idle_pct = 69;
          recv_idle_pct = 18;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      queued = 0;
      while (queued < 400) begin
        queue_random_name(n_bytes);
        queued += n_bytes;
      end
      while (pending_bytes.size() != 0 || in_valid_i) @(posedge clk_i);
      while (expected_names.size() != 0) @(posedge clk_i);
    end

    // The last result has been taken; give the pipeline a few more cycles in
    // case anything unexpected still comes out.
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("identifier_polynomial_hash_tb passed");
    end else begin
      $display("identifier_polynomial_hash_tb failed");
    end
    $finish;
  end

  // Watchdog: a correct run takes well under a tenth of this time.
  initial begin
    #2_000_000;
    $display("identifier_polynomial_hash_tb failed");
    $finish;
  end

endmodule
